// ----- rtl/icl_pkg.sv -----
// ----------------------------------------------------------------------------
// icl_pkg: shared types and constants for the interpolated color lookup
// Table geometry, fixed-point formats, register indexes and queue entry type.
// ----------------------------------------------------------------------------
package icl_pkg;

    localparam int TABLE_DEPTH     = 256;
    localparam int ADDR_BITS       = $clog2(TABLE_DEPTH);
    localparam int VALUE_BITS      = 16;
    localparam int TEMP_BITS       = 16;
    localparam int SCALE_BITS      = 32;
    localparam int SCALE_FRAC_BITS = 24;
    localparam int BLEND_BITS      = 16;
    localparam int COUNT_BITS      = 9;
    localparam int ENTRY_IDX_BITS  = 8;
    localparam int POS_BITS        = TEMP_BITS + SCALE_BITS;
    localparam int IDX_BITS        = POS_BITS - SCALE_FRAC_BITS;
    localparam int CFG_INDEX_BITS  = 2;

    localparam int QUEUE_DEPTH     = 4;
    localparam int QPTR_BITS       = $clog2(QUEUE_DEPTH);
    localparam int QCOUNT_BITS     = QPTR_BITS + 1;

    localparam logic [TEMP_BITS-1:0]  TEMP_LOW_RESET     = TEMP_BITS'(1000);
    localparam logic [TEMP_BITS-1:0]  TEMP_HIGH_RESET    = TEMP_BITS'(40000);
    localparam logic [SCALE_BITS-1:0] INDEX_SCALE_RESET  = SCALE_BITS'(109697);
    localparam logic [COUNT_BITS-1:0] ENTRIES_USED_RESET = COUNT_BITS'(256);

    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_LOAD   = 1'b1
    } opcode_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_TEMP_LOW     = 2'd0,
        CFG_TEMP_HIGH    = 2'd1,
        CFG_INDEX_SCALE  = 2'd2,
        CFG_ENTRIES_USED = 2'd3
    } cfg_index_t;

    typedef logic [VALUE_BITS-1:0] value_t;

    typedef struct packed {
        value_t red;
        value_t green;
        value_t blue;
        value_t lum;
    } entry_t;

    // one request between front and back
    typedef struct packed {
        logic                  is_load;
        logic [ADDR_BITS-1:0]  addr;    // load target, or lower lookup entry
        logic [BLEND_BITS-1:0] frac;    // weight of the upper entry
        entry_t                load;
    } qentry_t;

endpackage

// ----- rtl/icl_front.sv -----
// ----------------------------------------------------------------------------
// icl_front: configuration registers and request classification
// Clamps the temperature, scales the offset into a table position and
// resolves the entry address and blend fraction for the back end.
// ----------------------------------------------------------------------------
module icl_front
    import icl_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [SCALE_BITS-1:0]     cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      opcode,
    input  logic [TEMP_BITS-1:0]      temperature,
    input  logic [ENTRY_IDX_BITS-1:0] entry_index,
    input  logic [VALUE_BITS-1:0]     load_red,
    input  logic [VALUE_BITS-1:0]     load_green,
    input  logic [VALUE_BITS-1:0]     load_blue,
    input  logic [VALUE_BITS-1:0]     load_luminosity,
    output logic                      push_valid,
    input  logic                      push_ready,
    output qentry_t                   push_data
);

    typedef struct packed {
        logic                 is_load;
        logic [TEMP_BITS-1:0] offset;
        logic [ADDR_BITS-1:0] last;
        logic [ADDR_BITS-1:0] entry_addr;
        entry_t               load;
    } f1_t;

    typedef struct packed {
        logic                 is_load;
        logic [POS_BITS-1:0]  pos;
        logic [ADDR_BITS-1:0] last;
        logic [ADDR_BITS-1:0] entry_addr;
        entry_t               load;
    } f2_t;

    logic [TEMP_BITS-1:0]  temp_low_reg;
    logic [TEMP_BITS-1:0]  temp_high_reg;
    logic [SCALE_BITS-1:0] index_scale_reg;
    logic [COUNT_BITS-1:0] entries_used_reg;

    logic f1_valid_reg;
    logic f2_valid_reg;
    f1_t  f1_reg;
    f1_t  f1_next;
    f2_t  f2_reg;
    f2_t  f2_next;

    logic                 f1_ready;
    logic                 f2_ready;
    logic                 in_fire;
    logic                 is_load;
    logic                 load_in_range;
    logic [TEMP_BITS-1:0] t_clamped;
    logic [ADDR_BITS-1:0] last_entry;
    logic [IDX_BITS-1:0]  pos_idx;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_low_reg     <= TEMP_LOW_RESET;
            temp_high_reg    <= TEMP_HIGH_RESET;
            index_scale_reg  <= INDEX_SCALE_RESET;
            entries_used_reg <= ENTRIES_USED_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_TEMP_LOW:     temp_low_reg     <= cfg_data[TEMP_BITS-1:0];
                CFG_TEMP_HIGH:    temp_high_reg    <= cfg_data[TEMP_BITS-1:0];
                CFG_INDEX_SCALE:  index_scale_reg  <= cfg_data;
                CFG_ENTRIES_USED: entries_used_reg <= cfg_data[COUNT_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // ---- stage 1: clamp, offset, last entry ----
    assign f2_ready = !f2_valid_reg || push_ready;
    assign f1_ready = !f1_valid_reg || f2_ready;
    assign in_stall = !f1_ready;
    assign in_fire  = in_valid && f1_ready;

    assign is_load       = (opcode_t'(opcode) == OP_LOAD);
    assign load_in_range = (32'(entry_index) < TABLE_DEPTH);

    always_comb
    begin
        // floor first, then ceiling: an inverted range ends at temp_high
        t_clamped = temperature;
        if (t_clamped < temp_low_reg)
        begin
            t_clamped = temp_low_reg;
        end
        if (t_clamped > temp_high_reg)
        begin
            t_clamped = temp_high_reg;
        end

        if (entries_used_reg == '0)
        begin
            last_entry = '0;
        end
        else if (32'(entries_used_reg) > TABLE_DEPTH)
        begin
            last_entry = ADDR_BITS'(TABLE_DEPTH - 1);
        end
        else
        begin
            last_entry = ADDR_BITS'(entries_used_reg - COUNT_BITS'(1));
        end

        f1_next.is_load    = is_load;
        f1_next.offset     = (t_clamped > temp_low_reg) ? t_clamped - temp_low_reg : '0;
        f1_next.last       = last_entry;
        f1_next.entry_addr = ADDR_BITS'(entry_index);
        f1_next.load       = '{red: load_red, green: load_green, blue: load_blue,
                               lum: load_luminosity};
    end

    // ---- stage 2: offset times index scale ----
    always_comb
    begin
        f2_next.is_load    = f1_reg.is_load;
        f2_next.pos        = POS_BITS'(f1_reg.offset) * POS_BITS'(index_scale_reg);
        f2_next.last       = f1_reg.last;
        f2_next.entry_addr = f1_reg.entry_addr;
        f2_next.load       = f1_reg.load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end
        else
        begin
            if (f1_ready)
            begin
                // out-of-range loads are dropped here
                f1_valid_reg <= in_valid && !(is_load && !load_in_range);
            end
            if (f2_ready)
            begin
                f2_valid_reg <= f1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            f1_reg <= f1_next;
        end
        if (f2_ready && f1_valid_reg)
        begin
            f2_reg <= f2_next;
        end
    end

    // ---- classification into a queue request ----
    assign pos_idx = f2_reg.pos[POS_BITS-1:SCALE_FRAC_BITS];

    always_comb
    begin
        push_data.is_load = f2_reg.is_load;
        push_data.load    = f2_reg.load;
        if (f2_reg.is_load)
        begin
            push_data.addr = f2_reg.entry_addr;
            push_data.frac = '0;
        end
        else if (pos_idx >= IDX_BITS'(f2_reg.last))
        begin
            // at or past the end: last entry, no blend
            push_data.addr = f2_reg.last;
            push_data.frac = '0;
        end
        else
        begin
            push_data.addr = pos_idx[ADDR_BITS-1:0];
            push_data.frac = f2_reg.pos[SCALE_FRAC_BITS-1:SCALE_FRAC_BITS-BLEND_BITS];
        end
    end

    assign push_valid = f2_valid_reg;

    a_lookup_within_last: assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && !push_data.is_load) |-> (push_data.addr <= f2_reg.last))
        else $error("lookup address beyond last used entry");

    a_last_no_blend: assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && !push_data.is_load && push_data.addr == f2_reg.last)
        |-> (push_data.frac == '0))
        else $error("last entry lookup carries a blend fraction");

endmodule

// ----- rtl/icl_queue.sv -----
// ----------------------------------------------------------------------------
// icl_queue: short request queue between front and back
// Register-based FIFO so either side can stall without the other.
// ----------------------------------------------------------------------------
module icl_queue
    import icl_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push_valid,
    output logic    push_ready,
    input  qentry_t push_data,
    output logic    pop_valid,
    input  logic    pop_ready,
    output qentry_t pop_data
);

    qentry_t                slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg;
    logic [QPTR_BITS-1:0]   rd_ptr_reg;
    logic [QCOUNT_BITS-1:0] count_reg;
    logic [QCOUNT_BITS-1:0] count_next;
    logic                   push_fire;
    logic                   pop_fire;

    assign push_ready = (count_reg != QCOUNT_BITS'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push_fire && !pop_fire)
        begin
            count_next = count_reg + QCOUNT_BITS'(1);
        end
        else if (pop_fire && !push_fire)
        begin
            count_next = count_reg - QCOUNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push_fire)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_BITS'(1);
            end
            if (pop_fire)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCOUNT_BITS'(QUEUE_DEPTH))
        else $error("queue count overflow");

endmodule

// ----- rtl/icl_back.sv -----
// ----------------------------------------------------------------------------
// icl_back: table memory, interpolation and luminosity scaling
// Writes loads into the table, reads two neighbors per lookup, blends them
// and multiplies color by luminosity into the output register.
// ----------------------------------------------------------------------------
module icl_back
    import icl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    input  qentry_t               pop_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [VALUE_BITS-1:0] red_out,
    output logic [VALUE_BITS-1:0] green_out,
    output logic [VALUE_BITS-1:0] blue_out
);

    localparam int SUM_BITS  = VALUE_BITS + BLEND_BITS + 1;
    localparam int PROD_BITS = 2 * VALUE_BITS;

    // (a*(1-f) + b*f) >> BLEND_BITS; b is masked at f == 0 so an unloaded
    // neighbor never leaks in
    function automatic value_t blend(value_t a, value_t b, logic [BLEND_BITS-1:0] f);
        logic [BLEND_BITS:0] one_minus;
        logic [SUM_BITS-1:0] sum;
        one_minus = (BLEND_BITS+1)'(1 << BLEND_BITS) - {1'b0, f};
        sum = SUM_BITS'(a) * SUM_BITS'(one_minus);
        if (f != '0)
        begin
            sum = sum + SUM_BITS'(b) * SUM_BITS'(f);
        end
        return sum[VALUE_BITS+BLEND_BITS-1:BLEND_BITS];
    endfunction

    function automatic value_t scale(value_t c, value_t l);
        logic [PROD_BITS-1:0] prod;
        prod = PROD_BITS'(c) * PROD_BITS'(l);
        return prod[PROD_BITS-1:VALUE_BITS];
    endfunction

    entry_t table_mem [TABLE_DEPTH];

    logic                  rd_valid_reg;
    entry_t                rd_a_reg;
    entry_t                rd_b_reg;
    logic [BLEND_BITS-1:0] rd_frac_reg;

    logic                  bl_valid_reg;
    entry_t                bl_reg;

    logic                  out_valid_reg;
    value_t                red_reg;
    value_t                green_reg;
    value_t                blue_reg;

    logic                  pr_ready;
    logic                  bl_ready;
    logic                  rd_ready;
    logic                  pop_fire;
    logic [ADDR_BITS-1:0]  addr_upper;
    entry_t                blend_next;

    assign pr_ready  = !out_valid_reg || !out_stall;
    assign bl_ready  = !bl_valid_reg || pr_ready;
    assign rd_ready  = !rd_valid_reg || bl_ready;
    assign pop_ready = rd_ready;
    assign pop_fire  = pop_valid && pop_ready;

    // wraps past the end; only reached with a zero fraction
    assign addr_upper = pop_data.addr + ADDR_BITS'(1);

    // ---- read stage: table write or two-entry read ----
    always_ff @(posedge clk)
    begin
        if (pop_fire && pop_data.is_load)
        begin
            table_mem[pop_data.addr] <= pop_data.load;
        end
        if (pop_fire && !pop_data.is_load)
        begin
            rd_a_reg    <= table_mem[pop_data.addr];
            rd_b_reg    <= table_mem[addr_upper];
            rd_frac_reg <= pop_data.frac;
        end
    end

    // ---- blend stage ----
    always_comb
    begin
        blend_next.red   = blend(rd_a_reg.red,   rd_b_reg.red,   rd_frac_reg);
        blend_next.green = blend(rd_a_reg.green, rd_b_reg.green, rd_frac_reg);
        blend_next.blue  = blend(rd_a_reg.blue,  rd_b_reg.blue,  rd_frac_reg);
        blend_next.lum   = blend(rd_a_reg.lum,   rd_b_reg.lum,   rd_frac_reg);
    end

    always_ff @(posedge clk)
    begin
        if (bl_ready && rd_valid_reg)
        begin
            bl_reg <= blend_next;
        end
        if (pr_ready && bl_valid_reg)
        begin
            red_reg   <= scale(bl_reg.red,   bl_reg.lum);
            green_reg <= scale(bl_reg.green, bl_reg.lum);
            blue_reg  <= scale(bl_reg.blue,  bl_reg.lum);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg  <= 1'b0;
            bl_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rd_ready)
            begin
                rd_valid_reg <= pop_fire && !pop_data.is_load;
            end
            if (bl_ready)
            begin
                bl_valid_reg <= rd_valid_reg;
            end
            if (pr_ready)
            begin
                out_valid_reg <= bl_valid_reg;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign red_out   = red_reg;
    assign green_out = green_reg;
    assign blue_out  = blue_reg;

    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (pop_fire && pop_data.is_load) |=> !rd_valid_reg)
        else $error("load request entered the result pipeline");

    a_lookup_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (pop_fire && !pop_data.is_load) |=> rd_valid_reg)
        else $error("lookup request lost at the read stage");

    a_blend_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (bl_valid_reg && !pr_ready) |=> (bl_valid_reg && $stable(bl_reg)))
        else $error("blend stage changed while stalled");

endmodule

// ----- rtl/interpolated_color_table_lookup_top.sv -----
// ----------------------------------------------------------------------------
// interpolated_color_table_lookup_top: temperature to color lookup
// Interpolated color table with luminosity scaling, loaded by software.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid / in_stall): one request per accepted edge.
//   opcode load writes red, green, blue and luminosity of entry_index and
//   gives no result; opcode lookup clamps temperature, blends the two
//   neighboring entries and returns color times luminosity on the output
//   channel (out_valid / out_stall), in request order.
//   Config channel (cfg_valid / cfg_ready, always ready): index 0 temp_low,
//   1 temp_high, 2 index_scale (Q8.24), 3 entries_used. Write only while idle.
//   Path: a lookup result passes two front stages, the queue register,
//   the table read, the blend stage and the output register.
//   Throughput: one request per cycle unless stalled; the single
//   write/two-read table port set and the three-stage back pipeline keep pace.
//   A stalled output holds its result; the back pipeline fills, then the
//   four-entry queue, then the two front stages, then in_stall rises. Loads
//   take the table port in order, so a lookup right after a load sees the
//   new entry.
//   Reset clears the config registers to their defaults and empties all
//   stages; table contents are undefined until loaded.
// ----------------------------------------------------------------------------
module interpolated_color_table_lookup_top
    import icl_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [SCALE_BITS-1:0]     cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      opcode,
    input  logic [TEMP_BITS-1:0]      temperature,
    input  logic [ENTRY_IDX_BITS-1:0] entry_index,
    input  logic [VALUE_BITS-1:0]     load_red,
    input  logic [VALUE_BITS-1:0]     load_green,
    input  logic [VALUE_BITS-1:0]     load_blue,
    input  logic [VALUE_BITS-1:0]     load_luminosity,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [VALUE_BITS-1:0]     red_out,
    output logic [VALUE_BITS-1:0]     green_out,
    output logic [VALUE_BITS-1:0]     blue_out
);

    // front -> queue
    logic    push_valid;
    logic    push_ready;
    qentry_t push_data;

    // queue -> back
    logic    pop_valid;
    logic    pop_ready;
    qentry_t pop_data;

    // Front: config registers, clamp, scale multiply, address/fraction select
    icl_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .opcode          (opcode),
        .temperature     (temperature),
        .entry_index     (entry_index),
        .load_red        (load_red),
        .load_green      (load_green),
        .load_blue       (load_blue),
        .load_luminosity (load_luminosity),
        .push_valid      (push_valid),
        .push_ready      (push_ready),
        .push_data       (push_data)
    );

    // Decoupling queue: front only sees "not full", back only "not empty"
    icl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Back: table memory, blend, luminosity product, output register
    icl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out)
    );

endmodule

// ----- tb/sv/tb_interpolated_color_table_lookup_top.sv -----
// ----------------------------------------------------------------------------
// tb_interpolated_color_table_lookup_top: self-checking bench for the lookup
// Loads color/luminosity entries, runs lookups under many register settings,
// predicts each interpolated color in-bench and checks results in order.
// ----------------------------------------------------------------------------
module tb_interpolated_color_table_lookup_top;

    timeunit 1ns;
    timeprecision 1ps;

    import icl_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 12;
    localparam int SETTLE_CYCLES  = 12;
    localparam int CYCLE_LIMIT    = 500000;
    localparam int RANDOM_PER_SET = 60;
    localparam int HOLD_CYCLES    = 200;
    localparam int PRESSURE_SET   = 7;       // index into the settings plan
    localparam int MAX_REPORTS    = 10;

    // one request as offered on the input channel
    typedef struct {
        opcode_t                   op;
        logic [TEMP_BITS-1:0]      temp;
        logic [ENTRY_IDX_BITS-1:0] slot;
        entry_t                    data;
    } color_req_t;

    typedef struct packed {
        value_t red;
        value_t green;
        value_t blue;
    } rgb_t;

    typedef struct {
        logic [TEMP_BITS-1:0]  lo;
        logic [TEMP_BITS-1:0]  hi;
        logic [SCALE_BITS-1:0] scale;
        logic [COUNT_BITS-1:0] count;
    } reg_setting_t;

    // ------------------------------------------------------------------------
    // DUT signals; every bench-driven input is known from time zero
    // ------------------------------------------------------------------------
    logic                      clk             = 1'b0;
    logic                      rst_n           = 1'b0;
    logic                      cfg_valid       = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index       = '0;
    logic [SCALE_BITS-1:0]     cfg_data        = '0;
    logic                      in_valid        = 1'b0;
    logic                      in_stall;
    logic                      opcode          = 1'b0;
    logic [TEMP_BITS-1:0]      temperature     = '0;
    logic [ENTRY_IDX_BITS-1:0] entry_index     = '0;
    logic [VALUE_BITS-1:0]     load_red        = '0;
    logic [VALUE_BITS-1:0]     load_green      = '0;
    logic [VALUE_BITS-1:0]     load_blue       = '0;
    logic [VALUE_BITS-1:0]     load_luminosity = '0;
    logic                      out_valid;
    logic                      out_stall       = 1'b0;
    logic [VALUE_BITS-1:0]     red_out;
    logic [VALUE_BITS-1:0]     green_out;
    logic [VALUE_BITS-1:0]     blue_out;

    interpolated_color_table_lookup_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .opcode          (opcode),
        .temperature     (temperature),
        .entry_index     (entry_index),
        .load_red        (load_red),
        .load_green      (load_green),
        .load_blue       (load_blue),
        .load_luminosity (load_luminosity),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .red_out         (red_out),
        .green_out       (green_out),
        .blue_out        (blue_out)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    // shadow copy of the block: registers and the table
    logic [TEMP_BITS-1:0]  reg_temp_low     = TEMP_LOW_RESET;
    logic [TEMP_BITS-1:0]  reg_temp_high    = TEMP_HIGH_RESET;
    logic [SCALE_BITS-1:0] reg_index_scale  = INDEX_SCALE_RESET;
    logic [COUNT_BITS-1:0] reg_entries_used = ENTRIES_USED_RESET;
    entry_t                shadow_table [TABLE_DEPTH];

    // generator side: which entries have a load queued, so lookups never
    // touch an entry that was never written
    bit                    entry_loaded [TABLE_DEPTH];

    color_req_t pending_reqs [$];
    color_req_t active_req;
    rgb_t       expected_colors [$];

    int  cycle_count        = 0;
    int  gap_left           = 0;
    int  stall_left         = 0;
    int  mismatches         = 0;
    int  results_checked    = 0;
    int  loads_accepted     = 0;
    int  lookups_accepted   = 0;
    int  input_stall_cycles = 0;
    int  settings_applied   = 0;
    bit  pressure_armed     = 1'b0;
    logic hold_off          = 1'b0;

    // ------------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------------
    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("interpolated_color_table_lookup_top: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    // v = (a*(1-f) + b*f), f in Q0.16, truncated
    function automatic value_t mix_entries(value_t a, value_t b, logic [BLEND_BITS-1:0] w);
        logic [32:0] acc;
        acc = 33'(a) * (33'h1_0000 - 33'(w)) + 33'(b) * 33'(w);
        return acc[31:16];
    endfunction

    function automatic value_t apply_lum(value_t c, value_t l);
        logic [31:0] p;
        p = 32'(c) * 32'(l);
        return p[31:16];
    endfunction

    // effective last entry: a count of zero acts as one, above depth saturates
    function automatic int last_entry();
        int n;
        n = int'(reg_entries_used);
        if (n < 1) n = 1;
        if (n > TABLE_DEPTH) n = TABLE_DEPTH;
        return n - 1;
    endfunction

    function automatic rgb_t shade_lookup(logic [TEMP_BITS-1:0] temp_k);
        logic [TEMP_BITS-1:0]  t;
        logic [TEMP_BITS-1:0]  offset;
        logic [POS_BITS-1:0]   pos;
        logic [IDX_BITS-1:0]   seg;
        logic [BLEND_BITS-1:0] w;
        entry_t                lo_e;
        entry_t                hi_e;
        entry_t                mixed;
        int                    top;
        rgb_t                  res;
        // raise to the floor first, then lower to the ceiling; with an
        // inverted range this lands on temp_high and the offset is zero
        t = temp_k;
        if (t < reg_temp_low) t = reg_temp_low;
        if (t > reg_temp_high) t = reg_temp_high;
        offset = (t > reg_temp_low) ? t - reg_temp_low : '0;
        top = last_entry();
        pos = POS_BITS'(offset) * POS_BITS'(reg_index_scale);
        seg = pos[POS_BITS-1:SCALE_FRAC_BITS];
        w   = pos[SCALE_FRAC_BITS-1 -: BLEND_BITS];
        if (seg >= IDX_BITS'(top))
        begin
            // at or past the last used entry: no blending
            mixed = shadow_table[top];
        end
        else
        begin
            lo_e = shadow_table[ADDR_BITS'(seg)];
            hi_e = shadow_table[ADDR_BITS'(seg + 1)];
            mixed.red   = mix_entries(lo_e.red,   hi_e.red,   w);
            mixed.green = mix_entries(lo_e.green, hi_e.green, w);
            mixed.blue  = mix_entries(lo_e.blue,  hi_e.blue,  w);
            mixed.lum   = mix_entries(lo_e.lum,   hi_e.lum,   w);
        end
        res.red   = apply_lum(mixed.red,   mixed.lum);
        res.green = apply_lum(mixed.green, mixed.lum);
        res.blue  = apply_lum(mixed.blue,  mixed.lum);
        return res;
    endfunction

    // applied at the edge where the request is accepted
    function automatic void accept_request(color_req_t req);
        if (req.op == OP_LOAD)
        begin
            shadow_table[req.slot] = req.data;
            loads_accepted++;
        end
        else
        begin
            expected_colors.push_back(shade_lookup(req.temp));
            lookups_accepted++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Driver: pops pending requests, random gaps between them; payload
    // holds while the block stalls
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        // quiet windows with back-to-back requests
        if (((loads_accepted + lookups_accepted) / 128) % 4 == 1) return 0;
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && in_stall) input_stall_cycles++;
            if (in_valid && !in_stall) accept_request(active_req);
            if (!in_valid || !in_stall)
            begin
                // during the hold-off the sender keeps offering flat out
                if (gap_left > 0 && !hold_off)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    active_req = pending_reqs.pop_front();
                    in_valid        <= 1'b1;
                    opcode          <= active_req.op;
                    temperature     <= active_req.temp;
                    entry_index     <= active_req.slot;
                    load_red        <= active_req.data.red;
                    load_green      <= active_req.data.green;
                    load_blue       <= active_req.data.blue;
                    load_luminosity <= active_req.data.lum;
                    gap_left = pick_gap();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each accepted result against the oldest expectation,
    // then picks the stall for the next cycle
    // ------------------------------------------------------------------------
    function automatic void note_mismatch(string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("ERROR: %s", msg);
    endfunction

    function automatic void check_color(rgb_t got);
        rgb_t want;
        results_checked++;
        if (expected_colors.size() == 0)
        begin
            note_mismatch($sformatf("result with no lookup pending: r=%h g=%h b=%h",
                                    got.red, got.green, got.blue));
        end
        else
        begin
            want = expected_colors.pop_front();
            if (got.red !== want.red || got.green !== want.green ||
                got.blue !== want.blue)
                note_mismatch($sformatf(
                    "result %0d: expected r=%h g=%h b=%h, got r=%h g=%h b=%h",
                    results_checked, want.red, want.green, want.blue,
                    got.red, got.green, got.blue));
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        int r;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall) check_color('{red_out, green_out, blue_out});
            r = $urandom_range(0, 99);
            if (hold_off)
            begin
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (((cycle_count / 256) % 4) == 2)
            begin
                out_stall <= 1'b0;       // stretch with no back-pressure
            end
            else if (r < 80)
            begin
                out_stall <= 1'b0;
            end
            else if (r < 95)
            begin
                stall_left = $urandom_range(0, 2);
                out_stall <= 1'b1;
            end
            else
            begin
                stall_left = $urandom_range(8, 40);
                out_stall <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Long receiver hold-off: the block fills and must stall its input
    // ------------------------------------------------------------------------
    initial
    begin
        wait (pressure_armed);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic color_req_t make_load(int slot, entry_t data);
        color_req_t req;
        req.op   = OP_LOAD;
        req.temp = TEMP_BITS'($urandom());
        req.slot = ENTRY_IDX_BITS'(slot);
        req.data = data;
        return req;
    endfunction

    function automatic color_req_t make_lookup(int temp_k);
        color_req_t req;
        req.op   = OP_LOOKUP;
        req.temp = TEMP_BITS'(temp_k);
        req.slot = ENTRY_IDX_BITS'($urandom());
        req.data = entry_t'({$urandom(), $urandom()});
        return req;
    endfunction

    function automatic value_t pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 20) return '1;
        return VALUE_BITS'($urandom_range(0, 65535));
    endfunction

    function automatic entry_t random_entry();
        return '{red: pick_value(), green: pick_value(), blue: pick_value(),
                 lum: pick_value()};
    endfunction

    function automatic void queue_load(int slot, entry_t data);
        entry_loaded[slot] = 1'b1;
        pending_reqs.push_back(make_load(slot, data));
    endfunction

    function automatic int clamp_temp(int v);
        if (v < 0) return 0;
        if (v > 65535) return 65535;
        return v;
    endfunction

    // most lookups near or inside the configured range, some at its edges,
    // the rest anywhere
    function automatic int pick_temp();
        int r;
        int lo;
        int hi;
        int a;
        int b;
        r  = $urandom_range(0, 99);
        lo = int'(reg_temp_low);
        hi = int'(reg_temp_high);
        a  = clamp_temp(((lo < hi) ? lo : hi) - 40);
        b  = clamp_temp(((lo < hi) ? hi : lo) + 40);
        if (r < 15)
        begin
            case ($urandom_range(0, 7))
                0: return clamp_temp(lo - 1);
                1: return lo;
                2: return clamp_temp(lo + 1);
                3: return clamp_temp(hi - 1);
                4: return hi;
                5: return clamp_temp(hi + 1);
                6: return 0;
                default: return 65535;
            endcase
        end
        if (r < 70) return $urandom_range(a, b);
        return $urandom_range(0, 65535);
    endfunction

    // every entry a lookup may read gets a load before any lookup is queued
    function automatic void fill_used_entries();
        for (int e = 0; e <= last_entry(); e++)
            if (!entry_loaded[e]) queue_load(e, random_entry());
    endfunction

    function automatic void queue_random_requests(int count);
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 99) < 25)
                queue_load($urandom_range(0, TABLE_DEPTH - 1), random_entry());
            else
                pending_reqs.push_back(make_lookup(pick_temp()));
        end
    endfunction

    function automatic logic [SCALE_BITS-1:0] scale_for(int n, int lo, int hi);
        longint num;
        if (n < 1) n = 1;
        if (n > TABLE_DEPTH) n = TABLE_DEPTH;
        if (hi <= lo) return '1;
        num = longint'(n - 1) << SCALE_FRAC_BITS;
        return SCALE_BITS'(num / longint'(hi - lo));
    endfunction

    // one register write; valid stays high across back-to-back writes
    task automatic write_reg(cfg_index_t which, logic [SCALE_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= which;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (which)
            CFG_TEMP_LOW:     reg_temp_low     = value[TEMP_BITS-1:0];
            CFG_TEMP_HIGH:    reg_temp_high    = value[TEMP_BITS-1:0];
            CFG_INDEX_SCALE:  reg_index_scale  = value;
            CFG_ENTRIES_USED: reg_entries_used = value[COUNT_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(reg_setting_t s);
        write_reg(CFG_TEMP_LOW,     SCALE_BITS'(s.lo));
        write_reg(CFG_TEMP_HIGH,    SCALE_BITS'(s.hi));
        write_reg(CFG_INDEX_SCALE,  s.scale);
        write_reg(CFG_ENTRIES_USED, SCALE_BITS'(s.count));
        cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    // block is idle: nothing queued or offered, no result outstanding, and
    // loads (which give no result) have had time to leave the pipeline
    task automatic wait_until_drained();
        do @(posedge clk);
        while (pending_reqs.size() != 0 || in_valid || expected_colors.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        reg_setting_t plan [14];
        int           lo;
        int           hi;
        int           n;

        foreach (shadow_table[e]) shadow_table[e] = '0;
        foreach (entry_loaded[e]) entry_loaded[e] = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: four entries over 1000..1300 K, extremes of every field,
        // clamps on both sides, exact hits on entries, last entry, and a
        // lookup right behind a load of the entry it reads
        apply_setting('{lo: 16'd1000, hi: 16'd1300, scale: scale_for(4, 1000, 1300),
                        count: 9'd4});
        queue_load(0, '{red: 16'hFFFF, green: 16'h0000, blue: 16'hFFFF, lum: 16'hFFFF});
        queue_load(1, '{red: 16'h0000, green: 16'hFFFF, blue: 16'h5555, lum: 16'hAAAA});
        queue_load(2, '{red: 16'hAAAA, green: 16'h5555, blue: 16'hFFFF, lum: 16'h8000});
        queue_load(3, '{red: 16'hFFFF, green: 16'hFFFF, blue: 16'hFFFF, lum: 16'hFFFF});
        queue_load(255, '{red: 16'h0000, green: 16'h0000, blue: 16'h0000, lum: 16'h0000});
        pending_reqs.push_back(make_lookup(0));
        pending_reqs.push_back(make_lookup(999));
        pending_reqs.push_back(make_lookup(1000));
        pending_reqs.push_back(make_lookup(1001));
        pending_reqs.push_back(make_lookup(1099));
        pending_reqs.push_back(make_lookup(1100));
        pending_reqs.push_back(make_lookup(1150));
        pending_reqs.push_back(make_lookup(1250));
        pending_reqs.push_back(make_lookup(1299));
        pending_reqs.push_back(make_lookup(1300));
        pending_reqs.push_back(make_lookup(1301));
        pending_reqs.push_back(make_lookup(65535));
        queue_load(2, '{red: 16'h1234, green: 16'hFEDC, blue: 16'h0001, lum: 16'hFFFE});
        pending_reqs.push_back(make_lookup(1200));
        pending_reqs.push_back(make_lookup(1199));
        wait_until_drained();

        // register settings for the random part; extremes first, then odd
        // cases, then random ranges, and back to the reset values last
        plan[0]  = '{lo: 16'd0,     hi: 16'd65535, scale: scale_for(2, 0, 65535),
                     count: 9'd2};
        plan[1]  = '{lo: 16'd500,   hi: 16'd700,   scale: scale_for(16, 500, 700),
                     count: 9'd16};
        // a single entry: every lookup returns entry 0
        plan[2]  = '{lo: 16'd2000,  hi: 16'd3000,  scale: SCALE_BITS'($urandom()),
                     count: 9'd1};
        // count of zero acts as one; maximum scale
        plan[3]  = '{lo: 16'd100,   hi: 16'd50000, scale: '1, count: 9'd0};
        plan[4]  = '{lo: 16'd3000,  hi: 16'd9000,  scale: scale_for(64, 3000, 9000),
                     count: 9'd64};
        plan[5]  = '{lo: 16'd1000,  hi: 16'd40000, scale: scale_for(256, 1000, 40000),
                     count: 9'd256};
        // count above the depth saturates
        plan[6]  = '{lo: 16'd0,     hi: 16'd255,   scale: scale_for(256, 0, 255),
                     count: 9'd511};
        plan[7]  = '{lo: 16'd10000, hi: 16'd12000, scale: scale_for(256, 10000, 12000),
                     count: 9'd300};
        // inverted range: everything lands on entry 0 unblended
        plan[8]  = '{lo: 16'd30000, hi: 16'd20000, scale: 32'h0123_4567, count: 9'd256};
        plan[9]  = '{lo: 16'd0,     hi: 16'd65535, scale: '0, count: 9'd256};
        plan[10] = '{lo: 16'd1,     hi: 16'd65534, scale: '1, count: 9'd128};
        for (int p = 11; p < 13; p++)
        begin
            lo = $urandom_range(0, 60000);
            hi = lo + $urandom_range(1, 65535 - lo);
            n  = $urandom_range(2, TABLE_DEPTH);
            plan[p] = '{lo: TEMP_BITS'(lo), hi: TEMP_BITS'(hi), scale: scale_for(n, lo, hi),
                        count: COUNT_BITS'(n)};
        end
        plan[13] = '{lo: TEMP_LOW_RESET, hi: TEMP_HIGH_RESET, scale: INDEX_SCALE_RESET,
                     count: ENTRIES_USED_RESET};

        foreach (plan[p])
        begin
            apply_setting(plan[p]);
            fill_used_entries();
            if (p == PRESSURE_SET) pressure_armed = 1'b1;
            queue_random_requests(RANDOM_PER_SET);
            wait_until_drained();
        end

        if (expected_colors.size() != 0)
            note_mismatch($sformatf("%0d lookups never returned a result",
                                    expected_colors.size()));

        $display("summary: %0d loads and %0d lookups under %0d register settings",
                 loads_accepted, lookups_accepted, settings_applied);
        $display("summary: %0d results checked, input held off for %0d cycles, %0d errors",
                 results_checked, input_stall_cycles, mismatches);
        if (mismatches == 0)
            $display("interpolated_color_table_lookup_top: match");
        else
            $display("interpolated_color_table_lookup_top: mismatch");
        $finish;
    end

endmodule
